FILE: design/nttpd_pkg.sv
`timescale 1ns / 1ps
package nttpd_pkg;

    localparam int FREQ_W   = 24;
    localparam int LEN_W    = 8;
    localparam int PERIOD_W = 37;
    localparam int DUR_W    = 19;
    localparam int BPM_W    = 10;
    localparam int DUTY_W   = 7;
    localparam int QUOT_W   = 18;
    localparam int THIRD_W  = 17;
    localparam int RECIP_W  = 19;
    localparam int HIGH_W   = PERIOD_W + DUTY_W;
    localparam int FIGS     = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_BPM  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY = 1'b1;

    localparam logic [BPM_W-1:0]    BPM_RESET   = 10'd300;
    localparam logic [DUTY_W-1:0]   DUTY_RESET  = 7'd70;
    localparam logic [DUTY_W-1:0]   DUTY_MAX    = 7'd100;
    localparam logic [PERIOD_W-1:0] NS_NUMERATOR = 37'd100000000000;
    localparam logic [QUOT_W-1:0]   WHOLE_MS    = 18'd240000;
    // ceil(2^20 / 3): exact floor(q / 3) for any 18-bit q
    localparam logic [RECIP_W-1:0]  THIRD_RECIP = 19'd349526;
    localparam int                  THIRD_SHIFT = 20;
    localparam logic [HIGH_W-1:0]   HALF_HUNDRED = 44'd50;

    // Divide the 44-bit high-time product by 100 in two halves: the upper 23 bits
    // first, then the 7-bit remainder joined with the lower 21 bits.
    localparam int LO_W       = 21;
    localparam int HI_PART_W  = HIGH_W - LO_W;
    localparam int HQ_W       = 17;
    localparam int HR_W       = 7;
    localparam int MID_W      = HR_W + LO_W;
    localparam int HI_RECIP_W = 24;
    localparam int LO_RECIP_W = 29;
    // ceil(2^30 / 100): exact for any 23-bit value
    localparam logic [HI_RECIP_W-1:0] HI_RECIP = 24'd10737419;
    localparam int                    HI_SHIFT = 30;
    // ceil(2^35 / 100): exact for any 28-bit value
    localparam logic [LO_RECIP_W-1:0] LO_RECIP = 29'd343597384;
    localparam int                    LO_SHIFT = 35;

    typedef struct packed {
        logic [FREQ_W-1:0] freq_centihz;
        logic [LEN_W-1:0]  len_code;
    } in_item_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] period_ns;
        logic [PERIOD_W-1:0] duty_ns;
        logic                tone_on;
        logic [DUR_W-1:0]    duration_ms;
        logic                end_marker;
    } out_item_t;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [LEN_W-1:0]  len;
        logic [DUTY_W-1:0] duty;
    } beat_side_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic [DUR_W-1:0]  dur;
        logic              tone_on;
        logic              end_mark;
    } period_side_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic                tone_on;
        logic [DUR_W-1:0]    dur;
        logic                end_mark;
    } high_side_t;

endpackage

FILE: design/note_to_tone_period_and_duration.sv
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// in        in_valid / in_ready    in_data   (freq_centihz, len_code)
// out       out_valid / out_ready  out_data  (period_ns, duty_ns, tone_on,
//                                             duration_ms, end_marker)
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// One note enters per cycle; each result passes through two bit-per-stage
// divider pipelines (tempo 18, period 37 stages), three reciprocal-multiply
// stages for the duty divide by 100, plus five registers around them.
// Reset restores tempo 300 and duty 70 and empties the pipeline.
// A stall at the output freezes every stage at once; in_ready follows it.
module note_to_tone_period_and_duration (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  nttpd_pkg::in_item_t               in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output nttpd_pkg::out_item_t              out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [nttpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [nttpd_pkg::BPM_W-1:0]       cfg_data
);
    import nttpd_pkg::*;

    logic              adv;
    logic [BPM_W-1:0]  bpm_reg;
    logic [DUTY_W-1:0] duty_reg;

    logic              s0_valid_reg;
    logic [FREQ_W-1:0] s0_freq_reg;
    logic [LEN_W-1:0]  s0_len_reg;
    logic [BPM_W-1:0]  s0_bpm_reg;
    logic [DUTY_W-1:0] s0_duty_reg;

    beat_side_t        bd_side_in, bd_side_out;
    logic              bd_vld;
    logic [QUOT_W-1:0] bd_quo;

    logic                       e_valid_reg;
    logic [QUOT_W-1:0]          e_q_reg;
    logic [QUOT_W+RECIP_W-1:0]  e_prod_reg;
    beat_side_t                 e_side_reg;
    logic [THIRD_W-1:0]         e_third;
    logic [DUR_W-1:0]           dur_sum;

    logic                f_valid_reg;
    logic [PERIOD_W-1:0] f_num_reg;
    logic [FREQ_W-1:0]   f_freq_reg;
    period_side_t        f_side_reg;

    logic                pd_vld;
    logic [PERIOD_W-1:0] pd_quo;
    period_side_t        pd_side_out;

    logic              m_valid_reg;
    logic [HIGH_W-1:0] m_prod_reg;
    high_side_t        m_side_reg;

    logic                           n_valid_reg;
    logic [HI_PART_W-1:0]           n_hi_reg;
    logic [LO_W-1:0]                n_lo_reg;
    logic [HI_PART_W+HI_RECIP_W-1:0] n_prod_reg;
    high_side_t                     n_side_reg;
    logic [HQ_W-1:0]                n_qh;
    logic [HI_PART_W-1:0]           n_rem;

    logic              p_valid_reg;
    logic [HQ_W-1:0]   p_qh_reg;
    logic [MID_W-1:0]  p_mid_reg;
    high_side_t        p_side_reg;

    logic                         r_valid_reg;
    logic [HQ_W-1:0]              r_qh_reg;
    logic [MID_W+LO_RECIP_W-1:0]  r_prod_reg;
    high_side_t                   r_side_reg;

    logic [PERIOD_W-1:0] hd_quo;

    logic              out_valid_reg;
    out_item_t         out_data_reg;

    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpm_reg  <= BPM_RESET;
            duty_reg <= DUTY_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_BPM:  bpm_reg  <= cfg_data;
                CFG_DUTY: duty_reg <= cfg_data[DUTY_W-1:0];
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            e_valid_reg   <= 1'b0;
            f_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            n_valid_reg   <= 1'b0;
            p_valid_reg   <= 1'b0;
            r_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg  <= in_valid;
            e_valid_reg   <= bd_vld;
            f_valid_reg   <= e_valid_reg;
            m_valid_reg   <= pd_vld;
            n_valid_reg   <= m_valid_reg;
            p_valid_reg   <= n_valid_reg;
            r_valid_reg   <= p_valid_reg;
            out_valid_reg <= r_valid_reg;
        end
    end

    // Capture the note with clamped tempo and duty
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_freq_reg <= in_data.freq_centihz;
            s0_len_reg  <= in_data.len_code;
            s0_bpm_reg  <= (bpm_reg == '0) ? BPM_W'(1) : bpm_reg;
            s0_duty_reg <= (duty_reg > DUTY_MAX) ? DUTY_MAX : duty_reg;
        end
    end

    assign bd_side_in.freq = s0_freq_reg;
    assign bd_side_in.len  = s0_len_reg;
    assign bd_side_in.duty = s0_duty_reg;

    // Whole note time over tempo
    nttpd_div #(
        .NUM_W  (QUOT_W),
        .DEN_W  (BPM_W),
        .SIDE_W ($bits(beat_side_t))
    ) u_beat_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (s0_valid_reg),
        .in_num   (WHOLE_MS),
        .in_den   (s0_bpm_reg),
        .in_side  (bd_side_in),
        .out_vld  (bd_vld),
        .out_quo  (bd_quo),
        .out_side (bd_side_out)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_q_reg    <= bd_quo;
            e_prod_reg <= bd_quo * THIRD_RECIP;
            e_side_reg <= bd_side_out;
        end
    end

    assign e_third = e_prod_reg[THIRD_SHIFT +: THIRD_W];

    // Triplet figure 3*2^(i-1): floor(q/3) shifted; plain figure 2^i: q shifted
    always_comb
    begin
        dur_sum = '0;
        for (int i = 0; i < FIGS; i++)
        begin
            if (e_side_reg.len[i])
            begin
                if (i == 0)
                begin
                    dur_sum = dur_sum + DUR_W'(e_q_reg);
                end
                else if (e_side_reg.len[LEN_W-1])
                begin
                    dur_sum = dur_sum + DUR_W'(e_third >> (i - 1));
                end
                else
                begin
                    dur_sum = dur_sum + DUR_W'(e_q_reg >> i);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_num_reg           <= NS_NUMERATOR + PERIOD_W'(e_side_reg.freq >> 1);
            f_freq_reg          <= e_side_reg.freq;
            f_side_reg.duty     <= e_side_reg.duty;
            f_side_reg.dur      <= dur_sum;
            f_side_reg.tone_on  <= e_side_reg.freq != '0;
            f_side_reg.end_mark <= (e_side_reg.freq == '0) && (e_side_reg.len == '0);
        end
    end

    nttpd_div #(
        .NUM_W  (PERIOD_W),
        .DEN_W  (FREQ_W),
        .SIDE_W ($bits(period_side_t))
    ) u_period_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (f_valid_reg),
        .in_num   (f_num_reg),
        .in_den   (f_freq_reg),
        .in_side  (f_side_reg),
        .out_vld  (pd_vld),
        .out_quo  (pd_quo),
        .out_side (pd_side_out)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_prod_reg          <= pd_quo * pd_side_out.duty + HALF_HUNDRED;
            m_side_reg.period   <= pd_quo;
            m_side_reg.tone_on  <= pd_side_out.tone_on;
            m_side_reg.dur      <= pd_side_out.dur;
            m_side_reg.end_mark <= pd_side_out.end_mark;
        end
    end

    // Divide by 100: upper part by reciprocal, then remainder with lower part
    assign n_qh  = n_prod_reg[HI_SHIFT +: HQ_W];
    assign n_rem = n_hi_reg - HI_PART_W'(n_qh) * HI_PART_W'(DUTY_MAX);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n_hi_reg   <= m_prod_reg[HIGH_W-1 -: HI_PART_W];
            n_lo_reg   <= m_prod_reg[LO_W-1:0];
            n_prod_reg <= m_prod_reg[HIGH_W-1 -: HI_PART_W] * HI_RECIP;
            n_side_reg <= m_side_reg;

            p_qh_reg   <= n_qh;
            p_mid_reg  <= {n_rem[HR_W-1:0], n_lo_reg};
            p_side_reg <= n_side_reg;

            r_qh_reg   <= p_qh_reg;
            r_prod_reg <= p_mid_reg * LO_RECIP;
            r_side_reg <= p_side_reg;
        end
    end

    assign hd_quo = PERIOD_W'({r_qh_reg, r_prod_reg[LO_SHIFT +: LO_W]});

    // Drop the divider results for rests and the end marker, and the duration for the end marker
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg.period_ns   <= r_side_reg.tone_on ? r_side_reg.period : '0;
            out_data_reg.duty_ns     <= r_side_reg.tone_on ? hd_quo : '0;
            out_data_reg.tone_on     <= r_side_reg.tone_on;
            out_data_reg.duration_ms <= r_side_reg.end_mark ? '0 : r_side_reg.dur;
            out_data_reg.end_marker  <= r_side_reg.end_mark;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_end_silent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.end_marker |->
            !out_data.tone_on && out_data.duration_ms == '0)
        else $error("end marker carries tone or duration");

    a_rest_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.tone_on |->
            out_data.period_ns == '0 && out_data.duty_ns == '0)
        else $error("rest with nonzero period or duty");

    a_duty_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.duty_ns <= out_data.period_ns)
        else $error("duty time exceeds period");

endmodule

FILE: design/nttpd_div.sv
`timescale 1ns / 1ps
module nttpd_div #(
    parameter int NUM_W  = 37,
    parameter int DEN_W  = 24,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_vld,
    output logic [NUM_W-1:0]  out_quo,
    output logic [SIDE_W-1:0] out_side
);

    // One quotient bit per stage, restoring; the numerator word shifts left and
    // collects quotient bits at its low end.
    logic [NUM_W-1:0]  num_reg  [NUM_W];
    logic [DEN_W-1:0]  rem_reg  [NUM_W];
    logic [DEN_W-1:0]  den_reg  [NUM_W];
    logic [SIDE_W-1:0] side_reg [NUM_W];
    logic [NUM_W-1:0]  vld_reg;

    genvar k;
    generate
        for (k = 0; k < NUM_W; k++)
        begin : g_stage
            logic [NUM_W-1:0]  num_prev;
            logic [DEN_W-1:0]  rem_prev;
            logic [DEN_W-1:0]  den_prev;
            logic [SIDE_W-1:0] side_prev;
            logic              vld_prev;
            logic [DEN_W:0]    trial;
            logic [DEN_W:0]    diff;
            logic              fits;

            if (k == 0)
            begin : g_first
                assign num_prev  = in_num;
                assign rem_prev  = '0;
                assign den_prev  = in_den;
                assign side_prev = in_side;
                assign vld_prev  = in_vld;
            end
            else
            begin : g_next
                assign num_prev  = num_reg[k-1];
                assign rem_prev  = rem_reg[k-1];
                assign den_prev  = den_reg[k-1];
                assign side_prev = side_reg[k-1];
                assign vld_prev  = vld_reg[k-1];
            end

            assign trial = {rem_prev, num_prev[NUM_W-1]};
            assign fits  = trial >= {1'b0, den_prev};
            assign diff  = trial - {1'b0, den_prev};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vld_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    num_reg[k]  <= {num_prev[NUM_W-2:0], fits};
                    rem_reg[k]  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                    den_reg[k]  <= den_prev;
                    side_reg[k] <= side_prev;
                end
            end
        end
    endgenerate

    assign out_vld  = vld_reg[NUM_W-1];
    assign out_quo  = num_reg[NUM_W-1];
    assign out_side = side_reg[NUM_W-1];

endmodule

FILE: tb/note_to_tone_period_and_duration_tb.sv
`timescale 1ns / 1ps
module note_to_tone_period_and_duration_tb;
    import nttpd_pkg::*;

    typedef struct {
        in_item_t  note;
        bit        typed;
        out_item_t want;
    } step_row_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BPM_W-1:0]     cfg_data;

    logic [BPM_W-1:0]  tempo_bpm;
    logic [DUTY_W-1:0] duty_pct;
    out_item_t         pending_tones[$];
    step_row_t         steps[$];
    int                errors;
    int                notes_sent;
    int                rests_sent;
    int                ends_sent;
    int                reg_writes;
    bit                calm;
    int                stall_left;

    note_to_tone_period_and_duration u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic out_item_t tone_settings(in_item_t n);
        out_item_t         r;
        longint unsigned   f;
        longint unsigned   per;
        longint unsigned   bpm;
        longint unsigned   duty;
        longint unsigned   fig;
        longint unsigned   dur;
        f    = 64'(n.freq_centihz);
        bpm  = (tempo_bpm == 0) ? 64'd1 : 64'(tempo_bpm);
        duty = (duty_pct > 100) ? 64'd100 : 64'(duty_pct);
        r    = '0;
        if (f == 0 && n.len_code == 0)
        begin
            r.end_marker = 1'b1;
            return r;
        end
        if (f != 0)
        begin
            per         = (64'd100000000000 + f / 2) / f;
            r.period_ns = PERIOD_W'(per);
            r.duty_ns   = PERIOD_W'((per * duty + 50) / 100);
            r.tone_on   = 1'b1;
        end
        dur = 0;
        for (int i = 0; i < FIGS; i++)
        begin
            if (n.len_code[i])
            begin
                fig = 64'd1 << i;
                if (n.len_code[7])
                    fig = (fig * 3) / 2;
                dur += 240000 / (bpm * fig);
            end
        end
        r.duration_ms = DUR_W'(dur);
        return r;
    endfunction

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $time, what);
        errors++;
    endtask

    // Check each output transfer against the oldest pending expectation.
    always @(posedge clk)
    begin
        out_item_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_tones.size() == 0)
                report("result with nothing pending");
            else
            begin
                w = pending_tones.pop_front();
                if (out_data.period_ns !== w.period_ns)
                    report($sformatf("period_ns %0d want %0d", out_data.period_ns, w.period_ns));
                if (out_data.duty_ns !== w.duty_ns)
                    report($sformatf("duty_ns %0d want %0d", out_data.duty_ns, w.duty_ns));
                if (out_data.tone_on !== w.tone_on)
                    report($sformatf("tone_on %b want %b", out_data.tone_on, w.tone_on));
                if (out_data.duration_ms !== w.duration_ms)
                    report($sformatf("duration_ms %0d want %0d",
                                     out_data.duration_ms, w.duration_ms));
                if (out_data.end_marker !== w.end_marker)
                    report($sformatf("end_marker %b want %b", out_data.end_marker, w.end_marker));
            end
        end
    end

    // Receiver backpressure: random stall bursts until the calm phase.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 10);
        end
        else
            out_ready <= 1'b1;
    end

    task automatic add_row(input int f, input int len, input bit typed,
                           input longint unsigned per, input longint unsigned hi,
                           input bit on, input int dur, input bit fin);
        step_row_t s;
        s.note.freq_centihz  = FREQ_W'(f);
        s.note.len_code      = LEN_W'(len);
        s.typed              = typed;
        s.want.period_ns     = PERIOD_W'(per);
        s.want.duty_ns       = PERIOD_W'(hi);
        s.want.tone_on       = on;
        s.want.duration_ms   = DUR_W'(dur);
        s.want.end_marker    = fin;
        steps.push_back(s);
    endtask

    // Hold the write for its transfer, then drop cfg_valid and record the new tempo or duty.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= BPM_W'(value);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_BPM)
            tempo_bpm = BPM_W'(value);
        else
            duty_pct = DUTY_W'(value);
        reg_writes++;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_tones.size() != 0)
            @(posedge clk);
        repeat (110) @(posedge clk);
    endtask

    // Hold valid and payload until the transfer, then queue the expectation.
    task automatic send_note(input in_item_t n, input bit typed, input out_item_t want);
        in_valid <= 1'b1;
        in_data  <= n;
        do @(posedge clk); while (!in_ready);
        pending_tones.push_back(typed ? want : tone_settings(n));
        if (n.freq_centihz == 0 && n.len_code == 0)
            ends_sent++;
        else if (n.freq_centihz == 0)
            rests_sent++;
        else
            notes_sent++;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    function automatic in_item_t random_note();
        in_item_t n;
        case ($urandom_range(0, 9))
            0: n.freq_centihz = '0;
            1: n.freq_centihz = FREQ_W'($urandom_range(1, 255));
            2, 3: n.freq_centihz = FREQ_W'($urandom);
            default: n.freq_centihz = FREQ_W'($urandom_range(2000, 2000000));
        endcase
        case ($urandom_range(0, 9))
            0: n.len_code = 8'h00;
            1: n.len_code = 8'h80;
            default: n.len_code = LEN_W'($urandom);
        endcase
        return n;
    endfunction

    task automatic walk_table(input bit use_typed);
        foreach (steps[k])
            send_note(steps[k].note, use_typed && steps[k].typed, steps[k].want);
    endtask

    task automatic random_burst(input int count);
        out_item_t none;
        none = '0;
        repeat (count)
            send_note(random_note(), 1'b0, none);
    endtask

    initial
    begin
        errors     = 0;
        notes_sent = 0;
        rests_sent = 0;
        ends_sent  = 0;
        reg_writes = 0;
        calm       = 1'b0;
        tempo_bpm  = BPM_RESET;
        duty_pct   = DUTY_RESET;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_BPM;
        cfg_data   = '0;

        add_row(0, 8'h00, 1, 0, 0, 0, 0, 1);
        add_row(0, 8'h80, 1, 0, 0, 0, 0, 0);
        add_row(0, 8'h01, 1, 0, 0, 0, 800, 0);
        add_row(10000000, 8'h04, 1, 10000, 7000, 1, 200, 0);
        add_row(1, 8'h00, 1, 64'd100000000000, 64'd70000000000, 1, 0, 0);
        add_row(16777215, 8'h7F, 1, 5960, 4172, 1, 1587, 0);
        add_row(0, 8'hFF, 0, 0, 0, 0, 0, 0);
        add_row(1, 8'hFF, 0, 0, 0, 0, 0, 0);
        add_row(16777215, 8'h80, 0, 0, 0, 0, 0, 0);
        add_row(44000, 8'h02, 0, 0, 0, 0, 0, 0);
        add_row(26163, 8'h82, 0, 0, 0, 0, 0, 0);
        add_row(3, 8'h40, 0, 0, 0, 0, 0, 0);
        add_row(2, 8'hC0, 0, 0, 0, 0, 0, 0);
        add_row(24'hAAAAAA, 8'h55, 0, 0, 0, 0, 0, 0);
        add_row(24'h555555, 8'hAA, 0, 0, 0, 0, 0, 0);
        add_row(24'h800000, 8'h01, 0, 0, 0, 0, 0, 0);
        add_row(1000, 8'h7F, 0, 0, 0, 0, 0, 0);
        add_row(99999, 8'h10, 0, 0, 0, 0, 0, 0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset tempo and duty first, then the register extremes.
        walk_table(1'b1);
        random_burst(60);
        drain();
        write_reg(CFG_BPM, 1);
        write_reg(CFG_DUTY, 0);
        walk_table(1'b0);
        random_burst(70);
        drain();
        write_reg(CFG_BPM, 1023);
        write_reg(CFG_DUTY, 100);
        walk_table(1'b0);
        random_burst(70);
        drain();
        // Zero tempo acts as one; duty above 100 saturates.
        write_reg(CFG_BPM, 0);
        write_reg(CFG_DUTY, 127);
        walk_table(1'b0);
        random_burst(70);
        repeat (3)
        begin
            drain();
            write_reg(CFG_BPM, $urandom_range(0, 1023));
            write_reg(CFG_DUTY, $urandom_range(0, 127));
            random_burst(100);
        end
        drain();
        calm = 1'b1;
        write_reg(CFG_BPM, $urandom_range(1, 1023));
        write_reg(CFG_DUTY, $urandom_range(0, 100));
        random_burst(80);
        drain();

        $display("covered %0d tones, %0d rests, %0d end markers", notes_sent, rests_sent,
                 ends_sent);
        $display("%0d register writes across tempo and duty extremes", reg_writes);
        if (errors == 0 && pending_tones.size() == 0)
            $display("note_to_tone_period_and_duration regression: pass");
        else
            $display("note_to_tone_period_and_duration regression: fail");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout waiting for results");
        $display("note_to_tone_period_and_duration regression: fail");
        $finish;
    end

endmodule
